/* hdl/gdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, constants and tables for the date calculator
// Holds the controller states, the command and status bundles between the
// controller and the datapath, the month tables and the reciprocal constants.
// ----------------------------------------------------------------------------
package gdc_pkg;

	// Field widths fixed by the interface
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 12;
	localparam int STAT_W  = 2;
	localparam int ORD_W   = 9;
	localparam int WDAY_W  = 3;

	// Running year needs one bit more to hold the year past the last legal one
	localparam int CY_W = YEAR_W + 1;

	// Parameter defaults
	localparam int DEF_MAX_YEAR       = 9999;
	localparam int DEF_MAX_DAYS_AHEAD = 4095;

	// Calendar constants
	localparam int FIRST_YEAR         = 1753;
	localparam int LEAPS_BEFORE_FIRST = 425;   // leap years in 1..1752

	// y / 100 = (y * 5243) >> 19, exact for y below 43690
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV100_PW    = YEAR_W + 13;
	localparam int Q100_W       = 8;

	// v / 7 = (v * 18725) >> 17, exact for v below 43690
	localparam int WSUM_W      = 15;
	localparam int DIV7_MUL    = 18725;
	localparam int DIV7_SHIFT  = 17;
	localparam int DIV7_PW     = WSUM_W + 15;
	localparam int Q7_W        = DIV7_PW - DIV7_SHIFT;

	// Month constants
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_M400,
		S_CHK,
		S_SUM,
		S_MUL7,
		S_REM7,
		S_STEP,
		S_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div;
		logic m400;
		logic chk;
		logic sum;
		logic mul7;
		logic rem7;
		logic step;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic valid;
		logic step_last;
	} sts_t;

	// Length of a month; zero for a code that is no month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
						       input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before m of a common year
	function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [ORD_W-1:0] cnt;
		case (m)
			4'd2:    cnt = 9'd31;
			4'd3:    cnt = 9'd59;
			4'd4:    cnt = 9'd90;
			4'd5:    cnt = 9'd120;
			4'd6:    cnt = 9'd151;
			4'd7:    cnt = 9'd181;
			4'd8:    cnt = 9'd212;
			4'd9:    cnt = 9'd243;
			4'd10:   cnt = 9'd273;
			4'd11:   cnt = 9'd304;
			4'd12:   cnt = 9'd334;
			default: cnt = 9'd0;
		endcase
		return cnt;
	endfunction

	// Leap test from the year modulo 400
	function automatic logic leap_of_m400(input logic [8:0] r);
		return (r[1:0] == 2'd0) && !(r == 9'd100 || r == 9'd200 || r == 9'd300);
	endfunction

endpackage
`default_nettype wire

/* hdl/gdc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_ctrl: sequencer for the date calculator
// Walks the datapath through the divide, check and weekday steps; for a valid
// date it repeats the month step up to the advanced date or the year limit.
// ----------------------------------------------------------------------------
module gdc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire gdc_pkg::sts_t sts,
	output gdc_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import gdc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div   = 1'b1;
				state_nxt = S_M400;
			end
			S_M400: begin
				cmd.m400  = 1'b1;
				state_nxt = S_CHK;
			end
			S_CHK: begin
				cmd.chk   = 1'b1;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = S_MUL7;
			end
			S_MUL7: begin
				cmd.mul7  = 1'b1;
				state_nxt = S_REM7;
			end
			S_REM7: begin
				cmd.rem7  = 1'b1;
				state_nxt = sts.valid ? S_STEP : S_DONE;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.step_last) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

/* hdl/gdc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_dp: datapath of the date calculator
// Input registers, reciprocal divides for /100 and /7, validity and ordinal
// logic, and the month-at-a-time date stepper with year saturation.
// ----------------------------------------------------------------------------
module gdc_dp #(
	parameter int MAX_YEAR       = gdc_pkg::DEF_MAX_YEAR,
	parameter int MAX_DAYS_AHEAD = gdc_pkg::DEF_MAX_DAYS_AHEAD
) (
	input  wire logic                          clk,
	input  wire gdc_pkg::cmd_t                 cmd,
	output gdc_pkg::sts_t                      sts,
	input  wire logic [gdc_pkg::MONTH_W-1:0]   month_in,
	input  wire logic [gdc_pkg::DAY_W-1:0]     day_in,
	input  wire logic [gdc_pkg::YEAR_W-1:0]    year_in,
	input  wire logic [gdc_pkg::COUNT_W-1:0]   days_ahead,
	output logic      [gdc_pkg::STAT_W-1:0]    status,
	output logic                               leap_year,
	output logic      [gdc_pkg::ORD_W-1:0]     ordinal_day,
	output logic      [gdc_pkg::WDAY_W-1:0]    weekday,
	output logic      [gdc_pkg::MONTH_W-1:0]   next_month,
	output logic      [gdc_pkg::DAY_W-1:0]     next_day,
	output logic      [gdc_pkg::YEAR_W-1:0]    next_year
);
	import gdc_pkg::*;

	localparam logic [YEAR_W-1:0] SAT_YEAR = YEAR_W'(MAX_YEAR);

	// Item registers
	logic [MONTH_W-1:0] m_q;
	logic [DAY_W-1:0]   d_q;
	logic [YEAR_W-1:0]  y_q;
	logic [COUNT_W-1:0] n_q;

	// Intermediate results
	logic [Q100_W-1:0] q100_q;
	logic [8:0]        m400_q;     // running year modulo 400
	logic              leap_q;
	logic              valid_q;
	logic [ORD_W-1:0]  ord_q;
	logic [Q100_W-1:0] qm1_q;      // (year - 1) / 100
	logic [WSUM_W-1:0] wsum_q;
	logic [Q7_W-1:0]   q7_q;
	logic [WDAY_W-1:0] wd_q;

	// Stepper registers
	logic [MONTH_W-1:0] cm_q;
	logic [DAY_W-1:0]   cd_q;
	logic [CY_W-1:0]    cy_q;
	logic               sat_q;

	// Combinational helpers
	logic [DIV100_PW-1:0] prod100;
	logic [YEAR_W-1:0]    m400_full;
	logic                 leap_c;
	logic                 cent_c;
	logic [DAY_W-1:0]     len_in;
	logic                 valid_c;
	logic [ORD_W-1:0]     ord_c;
	logic [YEAR_W-1:0]    ym1;
	logic [15:0]          wsum_c;
	logic [DIV7_PW-1:0]   prod7;
	logic [WSUM_W-1:0]    wrem_c;
	logic [DAY_W-1:0]     len_cur;
	logic [DAY_W-1:0]     rem_c;
	logic                 fits_c;
	logic [CY_W-1:0]      cy_inc;
	logic                 over_c;

	// Divide by 100 through the reciprocal
	assign prod100 = DIV100_PW'(y_q) * DIV100_PW'(DIV100_MUL);

	// Year modulo 400 from the hundreds quotient
	assign m400_full = y_q - YEAR_W'(16'd400 * 16'(q100_q[Q100_W-1:2]));

	// Leap flag, validity and ordinal day of the input date
	assign leap_c  = leap_of_m400(m400_q);
	assign cent_c  = (m400_q == 9'd0 || m400_q == 9'd100 ||
			  m400_q == 9'd200 || m400_q == 9'd300);
	assign len_in  = month_len(m_q, leap_c);
	assign valid_c = (m_q >= MON_JAN) && (m_q <= MON_DEC) &&
			 (d_q != 5'd0) && (d_q <= len_in) &&
			 (int'(y_q) >= FIRST_YEAR) && (int'(y_q) <= MAX_YEAR);
	assign ord_c   = days_before(m_q) + ORD_W'(d_q) +
			 ORD_W'(leap_c && (m_q > MON_FEB));

	// Weekday sum: 365 = 1 mod 7, so years count once plus the leap days
	assign ym1    = y_q - YEAR_W'(1);
	assign wsum_c = 16'(y_q) - 16'(FIRST_YEAR) + 16'(ym1 >> 2) - 16'(qm1_q) +
			16'(qm1_q >> 2) - 16'(LEAPS_BEFORE_FIRST) + 16'(ord_q);

	// Divide by 7 through the reciprocal, then the remainder
	assign prod7  = DIV7_PW'(wsum_q) * DIV7_PW'(DIV7_MUL);
	assign wrem_c = wsum_q - WSUM_W'(q7_q) * WSUM_W'(7);

	// One month step of the stepper
	assign len_cur = month_len(cm_q, leap_of_m400(m400_q));
	assign rem_c   = len_cur - cd_q;
	assign fits_c  = (n_q <= COUNT_W'(rem_c));
	assign cy_inc  = cy_q + CY_W'(1);
	assign over_c  = (cm_q == MON_DEC) && (int'(cy_inc) > MAX_YEAR);

	assign sts.valid     = valid_q;
	assign sts.step_last = fits_c || over_c;

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= month_in;
			d_q   <= day_in;
			y_q   <= year_in;
			sat_q <= 1'b0;
			if (int'(days_ahead) > MAX_DAYS_AHEAD) begin
				n_q <= COUNT_W'(MAX_DAYS_AHEAD);
			end else begin
				n_q <= days_ahead;
			end
		end
		if (cmd.div) begin
			q100_q <= prod100[DIV100_PW-1:DIV100_SHIFT];
		end
		if (cmd.m400) begin
			m400_q <= m400_full[8:0];
		end
		if (cmd.chk) begin
			leap_q  <= leap_c;
			valid_q <= valid_c;
			ord_q   <= ord_c;
			qm1_q   <= q100_q - Q100_W'(cent_c);
			cm_q    <= m_q;
			cd_q    <= d_q;
			cy_q    <= CY_W'(y_q);
		end
		if (cmd.sum) begin
			wsum_q <= wsum_c[WSUM_W-1:0];
		end
		if (cmd.mul7) begin
			q7_q <= prod7[DIV7_PW-1:DIV7_SHIFT];
		end
		if (cmd.rem7) begin
			wd_q <= wrem_c[WDAY_W-1:0];
		end
		// Finish inside this month, or move to the first of the next
		if (cmd.step) begin
			if (fits_c) begin
				cd_q <= cd_q + n_q[DAY_W-1:0];
				n_q  <= '0;
			end else begin
				n_q  <= n_q - COUNT_W'(rem_c) - COUNT_W'(1);
				cd_q <= DAY_FIRST;
				if (cm_q == MON_DEC) begin
					cm_q   <= MON_JAN;
					cy_q   <= cy_inc;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
					if (over_c) begin
						sat_q <= 1'b1;
					end
				end else begin
					cm_q <= cm_q + MONTH_W'(1);
				end
			end
		end
	end

	// Result fields
	always_comb begin
		leap_year = leap_q;
		if (!valid_q) begin
			status      = ST_INVALID;
			ordinal_day = '0;
			weekday     = '0;
			next_month  = '0;
			next_day    = '0;
			next_year   = '0;
		end else if (sat_q) begin
			status      = ST_SAT;
			ordinal_day = ord_q;
			weekday     = wd_q;
			next_month  = MON_DEC;
			next_day    = DAY_LAST_DEC;
			next_year   = SAT_YEAR;
		end else begin
			status      = ST_OK;
			ordinal_day = ord_q;
			weekday     = wd_q;
			next_month  = cm_q;
			next_day    = cd_q;
			next_year   = cy_q[YEAR_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* hdl/gregorian_date_calculator.sv */
`default_nettype none
// Sequence: once start is taken, the divide, modulo, check, sum, multiply and
// remainder states run, then the month step repeats until the advanced date or
// the year limit is reached; an invalid date goes straight to done. The
// controller takes start only in idle, after done; busy is high meanwhile.
// Each result is shown for one cycle with done and cannot be stalled.
// Reset: arst_n returns the controller to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
// gregorian_date_calculator: date check, weekday and date advance
// Validates a Gregorian date, gives its leap flag, ordinal day and weekday,
// and advances it by a day count with saturation at the last year.
// ----------------------------------------------------------------------------
module gregorian_date_calculator #(
	parameter int MAX_YEAR       = gdc_pkg::DEF_MAX_YEAR,
	parameter int MAX_DAYS_AHEAD = gdc_pkg::DEF_MAX_DAYS_AHEAD
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	output logic                               done,
	input  wire logic [gdc_pkg::MONTH_W-1:0]   month_in,
	input  wire logic [gdc_pkg::DAY_W-1:0]     day_in,
	input  wire logic [gdc_pkg::YEAR_W-1:0]    year_in,
	input  wire logic [gdc_pkg::COUNT_W-1:0]   days_ahead,
	output logic      [gdc_pkg::STAT_W-1:0]    status,
	output logic                               leap_year,
	output logic      [gdc_pkg::ORD_W-1:0]     ordinal_day,
	output logic      [gdc_pkg::WDAY_W-1:0]    weekday,
	output logic      [gdc_pkg::MONTH_W-1:0]   next_month,
	output logic      [gdc_pkg::DAY_W-1:0]     next_day,
	output logic      [gdc_pkg::YEAR_W-1:0]    next_year
);
	import gdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	gdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath
	gdc_dp #(
		.MAX_YEAR       (MAX_YEAR),
		.MAX_DAYS_AHEAD (MAX_DAYS_AHEAD)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.month_in    (month_in),
		.day_in      (day_in),
		.year_in     (year_in),
		.days_ahead  (days_ahead),
		.status      (status),
		.leap_year   (leap_year),
		.ordinal_day (ordinal_day),
		.weekday     (weekday),
		.next_month  (next_month),
		.next_day    (next_day),
		.next_year   (next_year)
	);

endmodule
`default_nettype wire

/* tb/tb_gregorian_date_calculator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_calculator: self-checking bench for the date calculator
// Drives calendar corner cases and then random dates through the start/busy
// port with random idle gaps, predicts each result with a behavioral calendar
// model and checks every done beat, field by field, in arrival order.
// ----------------------------------------------------------------------------
module tb_gregorian_date_calculator;
	import gdc_pkg::*;

	localparam int unsigned LAST_YEAR    = DEF_MAX_YEAR;
	localparam int unsigned AHEAD_CAP    = DEF_MAX_DAYS_AHEAD;
	localparam int unsigned COUNT_MAX    = (1 << COUNT_W) - 1;
	localparam int          RANDOM_DATES = 1400;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          END_PAD      = 200;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] count;
	} date_query_t;

	// One queued beat plus how the sender paces it
	typedef struct packed {
		date_query_t q;
		logic [3:0]  gap;
		logic        gap_after_idle;
		logic        drain;
	} date_beat_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               leap;
		logic [ORD_W-1:0]   ordinal;
		logic [WDAY_W-1:0]  wday;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
	} date_result_t;

	typedef struct packed {
		date_query_t  q;
		date_result_t r;
	} date_check_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic [MONTH_W-1:0] month_in   = '0;
	logic [DAY_W-1:0]   day_in     = '0;
	logic [YEAR_W-1:0]  year_in    = '0;
	logic [COUNT_W-1:0] days_ahead = '0;
	logic               busy;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic               leap_year;
	logic [ORD_W-1:0]   ordinal_day;
	logic [WDAY_W-1:0]  weekday;
	logic [MONTH_W-1:0] next_month;
	logic [DAY_W-1:0]   next_day;
	logic [YEAR_W-1:0]  next_year;

	date_beat_t  pending_dates[$];
	date_check_t expected_dates[$];
	date_beat_t  in_hand;
	date_query_t on_ports;
	bit          holding      = 1'b0;
	int unsigned gap_left     = 0;
	bit          no_idle      = 1'b0;
	int          mismatches   = 0;
	int          beats_sent   = 0;
	int          results_seen = 0;
	int          ok_seen      = 0;
	int          invalid_seen = 0;
	int          sat_seen     = 0;
	int          stall_cycles = 0;

	gregorian_date_calculator #(
		.MAX_YEAR       (LAST_YEAR),
		.MAX_DAYS_AHEAD (AHEAD_CAP)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.month_in    (month_in),
		.day_in      (day_in),
		.year_in     (year_in),
		.days_ahead  (days_ahead),
		.status      (status),
		.leap_year   (leap_year),
		.ordinal_day (ordinal_day),
		.weekday     (weekday),
		.next_month  (next_month),
		.next_day    (next_day),
		.next_year   (next_year)
	);

	always #2 clk = ~clk;

	// Calendar arithmetic
	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			4, 6, 9, 11:           len = 30;
			2:                     len = is_leap(y) ? 29 : 28;
			1, 3, 5, 7, 8, 10, 12: len = 31;
			default:               len = 0;
		endcase
		return len;
	endfunction

	function automatic int unsigned leaps_through(input int unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	// Expected result for one date: validity, ordinal, weekday, advanced date
	function automatic date_result_t date_outcome(input date_query_t q);
		date_result_t r;
		int unsigned  m, d, y, n, k, ord, elapsed, left;
		bit           sat;
		m = q.month;
		d = q.day;
		y = q.year;
		n = q.count;
		r = '0;
		r.leap = is_leap(y);
		if (m < 1 || m > 12 || d < 1 || d > month_days(m, y) ||
		    y < FIRST_YEAR || y > LAST_YEAR) begin
			r.status = ST_INVALID;
			return r;
		end
		ord = d;
		for (k = 1; k < m; k++)
			ord += month_days(k, y);
		// 1753-01-01 counts as day 1 and is a Monday
		elapsed = 365 * (y - FIRST_YEAR) + leaps_through(y - 1) -
			  leaps_through(FIRST_YEAR - 1) + ord;
		r.ordinal = ORD_W'(ord);
		r.wday    = WDAY_W'(elapsed % 7);
		if (n > AHEAD_CAP)
			n = AHEAD_CAP;
		sat = 1'b0;
		// walk forward a month at a time
		while (n > 0 && !sat) begin
			left = month_days(m, y) - d;
			if (n <= left) begin
				d += n;
				n = 0;
			end else begin
				n -= left + 1;
				d = 1;
				m++;
				if (m > 12) begin
					m = 1;
					y++;
					if (y > LAST_YEAR)
						sat = 1'b1;
				end
			end
		end
		if (sat) begin
			r.status = ST_SAT;
			r.month  = MON_DEC;
			r.day    = DAY_LAST_DEC;
			r.year   = YEAR_W'(LAST_YEAR);
		end else begin
			r.status = ST_OK;
			r.month  = MONTH_W'(m);
			r.day    = DAY_W'(d);
			r.year   = YEAR_W'(y);
		end
		return r;
	endfunction

	task automatic queue_date(input int unsigned m, d, y, n, input bit drain);
		date_beat_t b;
		b.q.month        = MONTH_W'(m);
		b.q.day          = DAY_W'(d);
		b.q.year         = YEAR_W'(y);
		b.q.count        = COUNT_W'(n);
		b.gap            = no_idle ? 4'd0 : 4'($urandom_range(0, 13));
		b.gap_after_idle = 1'($urandom_range(0, 1));
		b.drain          = drain;
		pending_dates.push_back(b);
	endtask

	task automatic compare_field(input string field, input date_query_t q,
				     input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %0d/%0d/%0d +%0d: %s expected %0d, got %0d",
					 q.month, q.day, q.year, q.count, field, want, got);
		end
	endtask

	// Sender: record the beat taken, then pace and present the next one
	always @(posedge clk) begin : drive
		date_check_t chk;
		logic        taken;
		logic        go;
		taken = start && !busy;
		go    = start && !taken;
		if (taken) begin
			chk.q = on_ports;
			chk.r = date_outcome(on_ports);
			expected_dates.push_back(chk);
			beats_sent++;
		end
		if (arst_n && !go) begin
			if (!holding && pending_dates.size() != 0) begin
				in_hand  = pending_dates.pop_front();
				gap_left = int'(in_hand.gap);
				holding  = 1'b1;
			end
			if (holding) begin
				// a gap counts every cycle, or only cycles with the block idle
				if (gap_left != 0) begin
					if (!in_hand.gap_after_idle || !busy)
						gap_left--;
				end else if (!in_hand.drain || (!taken &&
					     expected_dates.size() <= (done ? 1 : 0))) begin
					month_in   <= in_hand.q.month;
					day_in     <= in_hand.q.day;
					year_in    <= in_hand.q.year;
					days_ahead <= in_hand.q.count;
					on_ports   = in_hand.q;
					holding    = 1'b0;
					go         = 1'b1;
				end
			end
		end
		start <= go;
	end

	// Checker: each done beat against the oldest prediction
	always @(posedge clk) begin : check
		date_check_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with no date pending: status %0d, %0d/%0d/%0d",
						 status, next_month, next_day, next_year);
			end else begin
				want = expected_dates.pop_front();
				case (want.r.status)
					ST_OK:      ok_seen++;
					ST_INVALID: invalid_seen++;
					default:    sat_seen++;
				endcase
				compare_field("status", want.q, 16'(want.r.status), 16'(status));
				compare_field("leap_year", want.q, 16'(want.r.leap), 16'(leap_year));
				compare_field("ordinal_day", want.q, 16'(want.r.ordinal),
					      16'(ordinal_day));
				compare_field("weekday", want.q, 16'(want.r.wday), 16'(weekday));
				compare_field("next_month", want.q, 16'(want.r.month), 16'(next_month));
				compare_field("next_day", want.q, 16'(want.r.day), 16'(next_day));
				compare_field("next_year", want.q, 16'(want.r.year), 16'(next_year));
			end
		end
	end

	// Watchdog: too long without any beat in either direction
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles with no beat", STALL_LIMIT);
				$display("tb_gregorian_date_calculator: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int          i;
		int unsigned m, d, y, n, pick;

		// Directed corners
		queue_date(1, 1, FIRST_YEAR, 0, 1'b0);          // first day, a Monday
		queue_date(12, 31, FIRST_YEAR - 1, 0, 1'b0);    // year before the calendar
		queue_date(1, 1, 0, 0, 1'b0);                   // year zero, leap flag still set
		queue_date(12, 31, LAST_YEAR, 0, 1'b0);         // last legal day
		queue_date(12, 31, LAST_YEAR, 1, 1'b0);         // one day past the end
		queue_date(1, 1, LAST_YEAR - 10, COUNT_MAX, 1'b0);
		queue_date(12, 31, LAST_YEAR - 11, COUNT_MAX, 1'b0);
		queue_date(6, 15, LAST_YEAR, 199, 1'b0);
		queue_date(1, 1, FIRST_YEAR, COUNT_MAX, 1'b0);  // longest walk
		queue_date(2, 28, 2000, 1, 1'b0);               // leap Feb 28 to Feb 29
		queue_date(2, 29, 2000, 1, 1'b0);               // leap Feb 29 to Mar 1
		queue_date(2, 28, 1900, 1, 1'b0);               // century, not leap
		queue_date(2, 29, 1900, 0, 1'b0);
		queue_date(2, 29, 2100, 0, 1'b0);
		queue_date(2, 29, 2400, 0, 1'b0);
		queue_date(2, 28, 2023, 1, 1'b0);
		queue_date(0, 15, 2020, 5, 1'b0);               // month zero
		queue_date(13, 1, 2020, 0, 1'b0);
		queue_date(15, 31, LAST_YEAR, COUNT_MAX, 1'b0);
		queue_date(4, 31, 2021, 0, 1'b0);               // day past month end
		queue_date(1, 0, 2021, 0, 1'b0);                // day zero
		queue_date(1, 31, 2021, 1, 1'b0);
		queue_date(12, 31, 2020, 1, 1'b0);              // year rollover
		queue_date(3, 1, 2024, 365, 1'b0);
		queue_date(7, 4, 1776, 0, 1'b0);

		// Random dates, mostly well formed; the first one waits for a drain
		for (i = 0; i < RANDOM_DATES; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			m    = $urandom_range(1, 12);
			y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
			if (pick < 12)
				y = $urandom_range(LAST_YEAR - 12, LAST_YEAR);
			else if (pick < 18)
				y = $urandom_range(FIRST_YEAR, FIRST_YEAR + 8);
			d = $urandom_range(1, month_days(m, y));
			if (pick >= 60 && pick < 70) begin
				// late February across the leap rules
				m = 2;
				case ($urandom_range(0, 2))
					0:       y = 100 * $urandom_range(18, 99);
					1:       y = 4 * $urandom_range(439, 2499);
					default: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
				endcase
				d = $urandom_range(27, 29);
			end else if (pick >= 70 && pick < 80) begin
				case ($urandom_range(0, 2))
					0:       d = month_days(m, y);
					1:       d = month_days(m, y) + 1;
					default: d = 0;
				endcase
			end else if (pick >= 80) begin
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
				y = $urandom_range(0, LAST_YEAR);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: n = $urandom_range(0, COUNT_MAX);
				4, 5, 6:    n = $urandom_range(0, 62);
				7:          n = $urandom_range(0, 1) ? COUNT_MAX : 0;
				default:    n = $urandom_range(300, 1500);
			endcase
			queue_date(m, d, y, n, (i == 0) || ($urandom_range(0, 249) == 0));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Drain everything, then watch for stray beats
		while (pending_dates.size() != 0 || holding || start)
			@(negedge clk);
		while (expected_dates.size() != 0)
			@(negedge clk);
		repeat (END_PAD) @(posedge clk);

		$display("%0d dates applied, %0d results checked", beats_sent, results_seen);
		$display("%0d valid, %0d rejected, %0d saturated", ok_seen, invalid_seen, sat_seen);
		if (mismatches == 0 && expected_dates.size() == 0)
			$display("tb_gregorian_date_calculator: clean");
		else
			$display("tb_gregorian_date_calculator: errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/gdc_pkg.sv
hdl/gdc_ctrl.sv
hdl/gdc_dp.sv
hdl/gregorian_date_calculator.sv
tb/tb_gregorian_date_calculator.sv
